### sv/html_entity_decoder_assert.svh
// ----------------------------------------------------------------------------
// html_entity_decoder_assert.svh
// Assertion macros for the HTML entity decoder.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_DECODER_ASSERT_SVH
`define HTML_ENTITY_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define HED_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define HED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, constants and the entity table of the HTML entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

    localparam int BYTE_W          = 8;
    localparam int HOLD_DEPTH      = 4;
    localparam int MAX_RESULTS     = 6;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int HOLD_CNT_W      = 3;
    localparam int N_ENT           = 12;
    localparam int ENT_LEN_W       = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Characters with a special role
    localparam logic [BYTE_W-1:0] CHAR_AMP   = 8'h26;
    localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

    // Entity bodies (text between '&' and ';'), unused tail bytes are zero
    localparam logic [BYTE_W-1:0] ENT_BODY [N_ENT][HOLD_DEPTH] = '{
        '{"q", "u", "o", "t"},
        '{"#", "3", "4", 8'h00},
        '{"a", "m", "p", 8'h00},
        '{"#", "3", "8", 8'h00},
        '{"a", "p", "o", "s"},
        '{"#", "3", "9", 8'h00},
        '{"l", "t", 8'h00, 8'h00},
        '{"#", "6", "0", 8'h00},
        '{"g", "t", 8'h00, 8'h00},
        '{"#", "6", "2", 8'h00},
        '{"n", "b", "s", "p"},
        '{"#", "1", "6", "0"}
    };

    localparam logic [ENT_LEN_W-1:0] ENT_LEN [N_ENT] = '{
        3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4
    };

    // Named forms compare without regard to letter case
    localparam logic ENT_FOLD [N_ENT] = '{
        1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
    };

    localparam logic [BYTE_W-1:0] ENT_VAL [N_ENT] = '{
        8'h22, 8'h22, 8'h26, 8'h26, 8'h27, 8'h27,
        8'h3C, 8'h3C, 8'h3E, 8'h3E, 8'h20, 8'h20
    };

    // One command for the back end: up to six bytes to emit in order
    typedef struct packed {
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] data;
        logic [RES_CNT_W-1:0]               count;
        logic                               last_end;
    } hed_cmd_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } hed_q_stat_t;

    function automatic logic [BYTE_W-1:0] lower_ascii(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= CHAR_UP_A && b <= CHAR_UP_Z)
        begin
            r = b + CASE_DELTA;
        end
        return r;
    endfunction

    function automatic logic byte_eq(input logic [BYTE_W-1:0] a,
                                     input logic [BYTE_W-1:0] b,
                                     input logic              fold);
        logic r;
        if (fold)
        begin
            r = (lower_ascii(a) == lower_ascii(b));
        end
        else
        begin
            r = (a == b);
        end
        return r;
    endfunction

endpackage

### sv/hed_in_if.sv
// ----------------------------------------------------------------------------
// hed_in_if
// Text input channel: one text byte and an end-of-text flag per transfer.
// ----------------------------------------------------------------------------
interface hed_in_if;
    import hed_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

### sv/hed_out_if.sv
// ----------------------------------------------------------------------------
// hed_out_if
// Decoded output channel: one byte plus framing flags per transfer.
// ----------------------------------------------------------------------------
interface hed_out_if;
    import hed_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              out_end;

    modport source (output valid, output out_byte, output run_last, output out_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input out_end,
                    output ready);
endinterface

### sv/hed_front.sv
// ----------------------------------------------------------------------------
// hed_front
// Accepts text bytes, tracks the held entity prefix and turns each byte
// into one emit command (or none while the byte is held and no hold is flushed).
// ----------------------------------------------------------------------------
module hed_front
(
    input  logic             clk,
    input  logic             rst_n,
    hed_in_if.sink           text,
    output hed_pkg::hed_cmd_t cmd,
    output logic             cmd_valid,
    input  logic             cmd_ready
);
    import hed_pkg::*;

    logic [BYTE_W-1:0]     held_reg [HOLD_DEPTH];
    logic [HOLD_CNT_W-1:0] count_reg;
    logic [HOLD_CNT_W-1:0] count_next;

    logic                  accept;
    logic                  holding;
    logic [HOLD_CNT_W-1:0] k;
    logic                  complete;
    logic                  prefix;
    logic [BYTE_W-1:0]     ent_val;
    logic                  ok;
    logic                  hold_ext;
    logic                  flush;
    logic                  fresh;
    logic                  start_hold;
    logic                  emit_c;
    logic [RES_CNT_W-1:0]  flush_n;
    logic [RES_CNT_W-1:0]  tail_pos;

    assign accept  = text.valid && text.ready;
    assign holding = (count_reg != '0);
    assign k       = count_reg - 1'b1;

    // Match held bytes plus the current byte against every entity body
    always_comb
    begin
        complete = 1'b0;
        prefix   = 1'b0;
        ent_val  = '0;
        ok       = 1'b0;
        for (int e = 0; e < N_ENT; e++)
        begin
            ok = (k <= ENT_LEN[e]);
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                if (k > HOLD_CNT_W'(i) && !byte_eq(held_reg[i], ENT_BODY[e][i], ENT_FOLD[e]))
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                if (k == ENT_LEN[e])
                begin
                    if (text.text_byte == CHAR_SEMI && !complete)
                    begin
                        complete = 1'b1;
                        ent_val  = ENT_VAL[e];
                    end
                end
                else if (byte_eq(text.text_byte, ENT_BODY[e][k[1:0]], ENT_FOLD[e]))
                begin
                    prefix = 1'b1;
                end
            end
        end
    end

    // Decide between extend, complete, flush and fresh handling
    always_comb
    begin
        hold_ext   = holding && !complete && prefix && !text.text_end &&
                     (k < HOLD_CNT_W'(HOLD_DEPTH));
        flush      = holding && !complete && !hold_ext;
        fresh      = !holding || flush;
        start_hold = fresh && (text.text_byte == CHAR_AMP) && !text.text_end;
        emit_c     = fresh && !start_hold;
        flush_n    = flush ? (RES_CNT_W'(k) + 1'b1) : '0;
        tail_pos   = flush_n;
    end

    // Build the command: the decoded value, or '&' and held bytes, then the current byte
    always_comb
    begin
        cmd.last_end = text.text_end;
        if (complete)
        begin
            cmd.count = RES_CNT_W'(1);
        end
        else
        begin
            cmd.count = flush_n + RES_CNT_W'(emit_c);
        end
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            if (complete)
            begin
                cmd.data[j] = ent_val;
            end
            else if (emit_c && tail_pos == RES_CNT_W'(j))
            begin
                cmd.data[j] = text.text_byte;
            end
            else if (j == 0)
            begin
                cmd.data[j] = CHAR_AMP;
            end
            else if (j <= HOLD_DEPTH)
            begin
                cmd.data[j] = held_reg[j - 1];
            end
            else
            begin
                cmd.data[j] = text.text_byte;
            end
        end
    end

    assign cmd_valid  = accept && (cmd.count != '0);
    assign text.ready = cmd_ready;

    // Hold count
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (hold_ext)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (start_hold)
            begin
                count_next = HOLD_CNT_W'(1);
            end
            else
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Held bytes, no reset
    always_ff @(posedge clk)
    begin
        if (accept && hold_ext)
        begin
            held_reg[k[1:0]] <= text.text_byte;
        end
    end
endmodule

### sv/hed_queue.sv
// ----------------------------------------------------------------------------
// hed_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module hed_queue
#(
    parameter int DEPTH = hed_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  hed_pkg::hed_cmd_t   in_cmd,
    input  logic                in_valid,
    output logic                in_ready,
    output hed_pkg::hed_cmd_t   out_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output hed_pkg::hed_q_stat_t stat
);
    import hed_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hed_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign in_ready   = !stat.full;
    assign out_valid  = !stat.empty;
    assign out_cmd    = entry_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = out_valid && out_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule

### sv/hed_back.sv
// ----------------------------------------------------------------------------
// hed_back
// Takes commands from the queue and emits their bytes one per transfer
// from an output register.
// ----------------------------------------------------------------------------
module hed_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  hed_pkg::hed_cmd_t cmd,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    hed_out_if.source         decoded
);
    import hed_pkg::*;

    hed_cmd_t             cmd_reg;
    hed_cmd_t             cmd_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic [RES_CNT_W-1:0] idx_reg;
    logic [RES_CNT_W-1:0] idx_next;
    logic                 last;
    logic                 out_acc;

    assign last    = (idx_reg == cmd_reg.count - 1'b1);
    assign out_acc = decoded.valid && decoded.ready;

    // Load a new command when idle or when the last byte leaves
    assign cmd_ready = !busy_reg || (last && decoded.ready);

    always_comb
    begin
        cmd_next  = cmd_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (cmd_ready)
        begin
            cmd_next  = cmd;
            busy_next = cmd_valid;
            idx_next  = '0;
        end
        else if (out_acc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // Output fields
    assign decoded.valid    = busy_reg;
    assign decoded.out_byte = cmd_reg.data[idx_reg];
    assign decoded.run_last = last;
    assign decoded.out_end  = last && cmd_reg.last_end;
endmodule

### sv/html_entity_decoder.sv
// ----------------------------------------------------------------------------
// html_entity_decoder
// Streams text bytes and replaces the six HTML character entities.
// ----------------------------------------------------------------------------
// Channels: text (sink) carries text_byte and text_end; decoded (source)
// carries out_byte, run_last and out_end. A transfer happens at a rising
// edge with valid and ready both high.
// Each accepted byte gives zero results (byte held as a possible entity),
// one result (decoded entity or plain byte) or up to six results ('&', the
// held bytes and the current byte when a hold fails or the text ends).
// The first result of an input byte passes the command queue and the
// output register of the back end before it shows on decoded.
// Throughput: one input byte per cycle while each byte gives at most one
// result and the receiver is ready; a byte with n results holds the output
// register until all n are sent. The command queue (QUEUE_DEPTH entries)
// lets input go on until full; text.ready is low exactly while it is full.
// Reset clears the hold and the queue; nothing is emitted until new input.
// When the receiver stalls, the current result holds on the output and
// the queue fills, after which input stalls too.
// ----------------------------------------------------------------------------
module html_entity_decoder
#(
    parameter int QUEUE_DEPTH = hed_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    hed_in_if.sink    text,
    hed_out_if.source decoded
);
    import hed_pkg::*;

    `include "html_entity_decoder_assert.svh"

    hed_cmd_t    f_cmd;
    logic        f_valid;
    logic        f_ready;
    hed_cmd_t    b_cmd;
    logic        b_valid;
    logic        b_ready;
    hed_q_stat_t q_stat;
    logic        q_push;
    logic        q_pop;

    // Front end: classify and track the hold
    hed_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .cmd       (f_cmd),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready)
    );

    // Command queue
    hed_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (f_cmd),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_cmd   (b_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .stat      (q_stat)
    );

    // Back end: emit bytes
    hed_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (b_cmd),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .decoded   (decoded)
    );

    assign q_push = f_valid && f_ready;
    assign q_pop  = b_valid && b_ready;

    // Checks
    `HED_ASSERT_NOW(a_push_not_full, q_push, !q_stat.full, "push into full queue")
    `HED_ASSERT_NOW(a_cmd_nonempty, f_valid, f_cmd.count != '0, "empty command pushed")
    `HED_ASSERT_NOW(a_end_is_last, decoded.valid && decoded.out_end, decoded.run_last,
                    "out_end without run_last")
    `HED_ASSERT_NEXT(a_pop_loads, q_pop, decoded.valid, "popped command not shown")
endmodule
